// File: rtl/rtu_frame_crc_checker_defines.svh
// ------------------------------------------------------------------------
// RTU frame CRC checker assertion macros
// Concurrent check macros used by the top-level RTL file; empty for synthesis.
// ------------------------------------------------------------------------
`ifndef RTU_FRAME_CRC_CHECKER_DEFINES_SVH
`define RTU_FRAME_CRC_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RFCC_ASSERT_IMP(lbl, ck, rstn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (a) |-> (b)) \
		else $error("rfcc check failed");

// next-cycle implication
`define RFCC_ASSERT_NXT(lbl, ck, rstn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (a) |=> (b)) \
		else $error("rfcc check failed");

`else

`define RFCC_ASSERT_IMP(lbl, ck, rstn, a, b)
`define RFCC_ASSERT_NXT(lbl, ck, rstn, a, b)

`endif

`endif

// File: rtl/rfcc_pkg.sv
// ------------------------------------------------------------------------
// RTU frame CRC checker package
// Shared types, codes and the CRC-16 byte update.
// ------------------------------------------------------------------------
package rfcc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned SEEN_W = 3;
	localparam logic [SEEN_W-1:0] SEEN_MAX = 3'd4;

	typedef enum logic [1:0] {
		KIND_UNIT    = 2'd0,
		KIND_FUNC    = 2'd1,
		KIND_PAYLOAD = 2'd2
	} byte_kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_CRC   = 2'd2
	} frame_status_t;

	// one classified item passed from front to back
	typedef struct packed {
		logic        fwd;
		logic [7:0]  data;
		byte_kind_t  kind;
		logic        last;
		logic        too_short;
		logic [15:0] recv_crc;
	} rfcc_entry_t;

	// reflected CRC-16, one byte, eight unrolled shift steps
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

// File: rtl/rtu_frame_crc_checker.sv
// ------------------------------------------------------------------------
// RTU frame CRC checker
// Checks the trailing CRC-16 of RTU frames and forwards frame bytes.
// ------------------------------------------------------------------------
// One byte is accepted per clock while in_ready is high, and each yields
// exactly one result. An accepted item passes through the two-entry queue
// and then the output register; the CRC byte update and verdict compare sit
// in front of the output register. While the output stalls, the queue and
// the output register hold three items before in_ready drops. When the stall
// clears, in_ready rises once a queue entry frees; input runs back to back.
// The last two bytes of a frame are held back and never forwarded. Every
// earlier byte comes out tagged unit, function or payload. The result of the
// final byte carries frame_done with status ok, too short (under four
// bytes) or CRC mismatch; the consumer drops the frame on a bad status.
`include "rtu_frame_crc_checker_defines.svh"

module rtu_frame_crc_checker import rfcc_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] out_byte,
	output logic [1:0] byte_kind,
	output logic       frame_done,
	output logic [1:0] frame_status
);

	rfcc_entry_t   wr_entry;
	rfcc_entry_t   rd_entry;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_not_empty;
	byte_kind_t    kind;
	frame_status_t status;

	rfcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.q_full     (q_full),
		.rx_byte    (rx_byte),
		.frame_last (frame_last),
		.in_ready   (in_ready),
		.push       (push),
		.entry      (wr_entry)
	);

	rfcc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.rd_entry  (rd_entry),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	rfcc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.entry        (rd_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_valid   (byte_valid),
		.out_byte     (out_byte),
		.byte_kind    (kind),
		.frame_done   (frame_done),
		.frame_status (status)
	);

	assign byte_kind    = kind;
	assign frame_status = status;

	// a good frame has at least four bytes, so its closing result forwards one
	`RFCC_ASSERT_IMP(a_ok_frame_forwards, clk, arst_n,
		out_valid && frame_done && status == STAT_OK, byte_valid)
	// status is only reported on the closing result
	`RFCC_ASSERT_IMP(a_status_only_when_done, clk, arst_n,
		out_valid && !frame_done, status == STAT_OK)
	// held-back bytes come out as zero unit tags
	`RFCC_ASSERT_IMP(a_idle_byte_zero, clk, arst_n,
		out_valid && !byte_valid, out_byte == 8'h00 && kind == KIND_UNIT)
	// the queue never takes an item while full
	`RFCC_ASSERT_NXT(a_no_push_when_full, clk, arst_n, q_full && !pop, !push || !q_full)

endmodule

// File: rtl/rfcc_front.sv
// ------------------------------------------------------------------------
// RTU frame CRC checker front end
// Two-byte delay line and byte counter; classifies each accepted item.
// ------------------------------------------------------------------------
module rfcc_front import rfcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        q_full,
	input  logic [7:0]  rx_byte,
	input  logic        frame_last,
	output logic        in_ready,
	output logic        push,
	output rfcc_entry_t entry
);

	logic [7:0]        older_q;
	logic [7:0]        newer_q;
	logic [SEEN_W-1:0] seen_q;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		entry           = '0;
		entry.fwd       = (seen_q >= SEEN_W'(2));
		entry.data      = entry.fwd ? older_q : 8'h00;
		entry.kind      = KIND_UNIT;
		if (seen_q == SEEN_W'(3))
			entry.kind = KIND_FUNC;
		else if (seen_q >= SEEN_MAX)
			entry.kind = KIND_PAYLOAD;
		entry.last      = frame_last;
		entry.too_short = (seen_q < SEEN_W'(3));
		entry.recv_crc  = {rx_byte, newer_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= 8'h00;
			newer_q <= 8'h00;
			seen_q  <= '0;
		end else if (push) begin
			if (frame_last) begin
				older_q <= 8'h00;
				newer_q <= 8'h00;
				seen_q  <= '0;
			end else begin
				older_q <= newer_q;
				newer_q <= rx_byte;
				if (seen_q < SEEN_MAX)
					seen_q <= seen_q + SEEN_W'(1);
			end
		end
	end

endmodule

// File: rtl/rfcc_queue.sv
// ------------------------------------------------------------------------
// RTU frame CRC checker item queue
// Small register FIFO decoupling the front end from the CRC back end.
// ------------------------------------------------------------------------
module rfcc_queue import rfcc_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  rfcc_entry_t wr_entry,
	input  logic        pop,
	output rfcc_entry_t rd_entry,
	output logic        full,
	output logic        not_empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	rfcc_entry_t       mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/rfcc_back.sv
// ------------------------------------------------------------------------
// RTU frame CRC checker back end
// Running CRC, end-of-frame verdict and the registered result stage.
// ------------------------------------------------------------------------
module rfcc_back import rfcc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  rfcc_entry_t   entry,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          byte_valid,
	output logic [7:0]    out_byte,
	output byte_kind_t    byte_kind,
	output logic          frame_done,
	output frame_status_t frame_status
);

	logic [15:0]   crc_q;
	logic [15:0]   crc_next;
	frame_status_t status;
	logic          out_valid_q;

	assign pop = q_not_empty && (!out_valid_q || out_ready);

	always_comb begin
		crc_next = entry.fwd ? crc_fold(crc_q, entry.data) : crc_q;
		status   = STAT_OK;
		if (entry.last) begin
			if (entry.too_short)
				status = STAT_SHORT;
			else if (crc_next != entry.recv_crc)
				status = STAT_CRC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				crc_q <= entry.last ? CRC_INIT : crc_next;
			if (pop)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded whenever an item moves into the output stage
	always_ff @(posedge clk) begin
		if (pop) begin
			byte_valid   <= entry.fwd;
			out_byte     <= entry.data;
			byte_kind    <= entry.kind;
			frame_done   <= entry.last;
			frame_status <= status;
		end
	end

	assign out_valid = out_valid_q;

endmodule
